/* sv/lpb_pkg.sv */
// ---------------------------------------------------------------------------
// lpb_pkg
// Shared types and constants for the LED pixel buffer.
// ---------------------------------------------------------------------------
package lpb_pkg;

  localparam int IDX_W   = 16;
  localparam int COLOR_W = 24;
  localparam int LCNT_W  = 11;
  localparam int OP_W    = 3;

  localparam logic [LCNT_W-1:0] LED_COUNT_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_t;

  // pixel memory access, one write and one read port
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic               show;
  } res_t;

endpackage

/* sv/lpb_ram.sv */
// ---------------------------------------------------------------------------
// lpb_ram
// Pixel color memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lpb_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  lpb_pkg::mem_req_t                 req,
  output logic [lpb_pkg::COLOR_W-1:0]       rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [lpb_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

/* sv/lpb_ctrl.sv */
// ---------------------------------------------------------------------------
// lpb_ctrl
// Operation sequencer: decodes a word, walks pixel runs through the memory
// with read-compare-write, tracks the changed and disabled flags.
// ---------------------------------------------------------------------------
module lpb_ctrl #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lpb_pkg::OP_W-1:0]           operation,
  input  logic [lpb_pkg::IDX_W-1:0]          index,
  input  logic [lpb_pkg::IDX_W-1:0]          count,
  input  logic [lpb_pkg::COLOR_W-1:0]        color,
  input  logic                               disable_value,
  input  logic [lpb_pkg::LCNT_W-1:0]         led_count,
  output lpb_pkg::mem_req_t                  mem_req,
  input  logic [lpb_pkg::COLOR_W-1:0]        rdata,
  output lpb_pkg::res_t                      res,
  input  logic                               res_take
);

  localparam int IW = lpb_pkg::IDX_W;
  localparam int CW = lpb_pkg::COLOR_W;
  localparam logic [IW-1:0] MAX_V  = IW'(MAX_LEDS);
  localparam logic [IW-1:0] LAST_V = IW'(MAX_LEDS - 1);

  lpb_pkg::state_t state, state_next;

  logic [IW-1:0] cur;
  logic [IW-1:0] stop;
  logic [CW-1:0] run_color;
  logic          pipe_valid;
  logic [IW-1:0] pipe_addr;
  logic          changed;
  logic          disabled;
  logic [CW-1:0] res_color;
  logic          res_show;

  logic          accept;
  logic [IW-1:0] active;
  logic          in_range;
  logic [IW:0]   sum;
  logic [IW-1:0] fill_stop;
  logic          pix_diff;

  logic          dec_run;
  logic          dec_read;
  logic [IW-1:0] dec_first;
  logic [IW-1:0] dec_stop;
  logic [CW-1:0] dec_color;
  logic          dec_show;

  assign accept    = in_valid && in_ready;
  assign active    = ({5'd0, led_count} > MAX_V) ? MAX_V : {5'd0, led_count};
  assign in_range  = index < active;
  assign sum       = {1'b0, index} + {1'b0, count};
  assign fill_stop = (sum > {1'b0, active}) ? active : sum[IW-1:0];
  assign pix_diff  = pipe_valid && (rdata != run_color);

  // operation decode
  always_comb begin
    dec_run   = 1'b0;
    dec_read  = 1'b0;
    dec_first = index;
    dec_stop  = fill_stop;
    dec_color = color;
    dec_show  = 1'b0;
    unique case (operation)
      lpb_pkg::OP_WRITE: begin
        dec_run  = in_range;
        dec_stop = index + 1'b1;
      end
      lpb_pkg::OP_FILL: begin
        dec_run = in_range && (count != '0);
      end
      lpb_pkg::OP_READ: begin
        dec_read = in_range;
      end
      lpb_pkg::OP_UPDATE: begin
        dec_show = !disabled && changed;
      end
      lpb_pkg::OP_DISABLE: begin
        dec_run   = active != '0;
        dec_first = '0;
        dec_stop  = active;
        dec_color = '0;
        dec_show  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lpb_pkg::ST_CLEAR: begin
        if (cur == LAST_V) state_next = lpb_pkg::ST_IDLE;
      end
      lpb_pkg::ST_IDLE: begin
        if (accept) begin
          if (dec_run) state_next = lpb_pkg::ST_RUN;
          else if (dec_read) state_next = lpb_pkg::ST_READ;
          else state_next = lpb_pkg::ST_RESULT;
        end
      end
      lpb_pkg::ST_RUN: begin
        if (cur + 1'b1 == stop) state_next = lpb_pkg::ST_DRAIN;
      end
      lpb_pkg::ST_DRAIN: state_next = lpb_pkg::ST_RESULT;
      lpb_pkg::ST_READ:  state_next = lpb_pkg::ST_RESULT;
      lpb_pkg::ST_RESULT: begin
        if (res_take) state_next = lpb_pkg::ST_IDLE;
      end
      default: state_next = lpb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == lpb_pkg::ST_IDLE);
    mem_req.re    = (state == lpb_pkg::ST_RUN) ||
                    ((state == lpb_pkg::ST_IDLE) && accept && dec_read);
    mem_req.raddr = (state == lpb_pkg::ST_IDLE) ? index : cur;
    // write back only where the stored color differs; the clearing pass writes every pixel
    mem_req.we    = (state == lpb_pkg::ST_CLEAR) || pix_diff;
    mem_req.waddr = (state == lpb_pkg::ST_CLEAR) ? cur : pipe_addr;
    mem_req.wdata = (state == lpb_pkg::ST_CLEAR) ? '0 : run_color;
    res.valid     = (state == lpb_pkg::ST_RESULT);
    res.color     = res_color;
    res.show      = res_show;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lpb_pkg::ST_CLEAR;
      cur        <= '0;
      pipe_valid <= 1'b0;
      changed    <= 1'b0;
      disabled   <= 1'b0;
    end else begin
      state      <= state_next;
      pipe_valid <= (state == lpb_pkg::ST_RUN);
      if (pix_diff) changed <= 1'b1;
      unique case (state)
        lpb_pkg::ST_CLEAR: cur <= cur + 1'b1;
        lpb_pkg::ST_IDLE: begin
          if (accept) begin
            cur <= dec_first;
            if (operation == lpb_pkg::OP_UPDATE && dec_show) changed <= 1'b0;
            if (operation == lpb_pkg::OP_DISABLE) disabled <= disable_value;
          end
        end
        lpb_pkg::ST_RUN: cur <= cur + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr <= cur;
    if (accept) begin
      stop      <= dec_stop;
      run_color <= dec_color;
      res_color <= '0;
      res_show  <= dec_show;
    end
    if (state == lpb_pkg::ST_READ) res_color <= rdata;
  end

endmodule

/* sv/led_pixel_buffer_with_dirty_flag_top.sv */
// ---------------------------------------------------------------------------
// led_pixel_buffer_with_dirty_flag_top
// 24-bit RGB pixel buffer with changed flag, show strobe and blanking.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | operation, index, count, color, disable_value
//  out     | out_valid/out_ready | read_color, show_frame
//  cfg     | cfg_we              | cfg_data (led_count)
//
//  An in-range write pixel, fill or set disable walks its pixels through the
//  run, drain and result states; the run streams one pixel a cycle through
//  the memory read port, compare and write-back. Read passes through the
//  read and result states, update/other go straight to result. After reset
//  a clearing pass over all MAX_LEDS pixels blanks the memory; in_ready
//  stays low until it ends. A new word is taken while the output register
//  still holds the previous result; a stalled output holds the next result in the sequencer.
module led_pixel_buffer_with_dirty_flag_top #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lpb_pkg::OP_W-1:0]         operation,
  input  logic [lpb_pkg::IDX_W-1:0]        index,
  input  logic [lpb_pkg::IDX_W-1:0]        count,
  input  logic [lpb_pkg::COLOR_W-1:0]      color,
  input  logic                             disable_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lpb_pkg::COLOR_W-1:0]      read_color,
  output logic                             show_frame,
  input  logic                             cfg_we,
  input  logic [lpb_pkg::LCNT_W-1:0]       cfg_data
);

  logic [lpb_pkg::LCNT_W-1:0]  led_count;
  lpb_pkg::mem_req_t           mem_req;
  logic [lpb_pkg::COLOR_W-1:0] rdata;
  lpb_pkg::res_t               res;
  logic                        res_take;

  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= lpb_pkg::LED_COUNT_RESET;
    end else if (cfg_we) begin
      led_count <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      read_color <= res.color;
      show_frame <= res.show;
    end
  end

  lpb_ctrl #(
    .MAX_LEDS (MAX_LEDS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .index         (index),
    .count         (count),
    .color         (color),
    .disable_value (disable_value),
    .led_count     (led_count),
    .mem_req       (mem_req),
    .rdata         (rdata),
    .res           (res),
    .res_take      (res_take)
  );

  lpb_ram #(
    .DEPTH (MAX_LEDS)
  ) u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

/* sv/lpb_checker.sv */
// ---------------------------------------------------------------------------
// lpb_checker
// Port-level checks for the LED pixel buffer, bound to the top level.
// ---------------------------------------------------------------------------
module lpb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lpb_pkg::COLOR_W-1:0]  read_color,
  input logic                         show_frame
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_color) && $stable(show_frame))
    else $error("output word changed while stalled");

  // one word at a time: ready drops after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // a show strobe never carries read data
  a_show_no_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && show_frame |-> read_color == '0)
    else $error("show_frame with nonzero read_color");

  // reset starts the clearing pass with nothing to send
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("busy or result after reset");

endmodule

bind led_pixel_buffer_with_dirty_flag_top lpb_checker u_lpb_checker (.*);
